// ----- sv/cfb_pkg.sv -----
// ----------------------------------------------------------------------------
// cfb_pkg
// Shared types and constants for the command frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package cfb_pkg;

  localparam logic [7:0] SyncFirst  = 8'hFF;
  localparam logic [7:0] SyncSecond = 8'h55;
  localparam logic [7:0] LenBias    = 8'd5;

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_PAYLOAD = 1'b1;

  localparam int QDepth    = 4;
  localparam int QPtrWidth = $clog2(QDepth);
  localparam int QCntWidth = $clog2(QDepth + 1);

  typedef struct packed {
    logic       command;
    logic [7:0] packet_type;
    logic [7:0] transaction_id;
    logic [7:0] op_code;
    logic [7:0] payload_length;
    logic [7:0] data_byte;
  } cfb_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } cfb_out_t;

  // One classified operation handed from the front to the back.
  typedef struct packed {
    logic       is_header;
    logic       has_ck;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] ck;
  } cfb_entry_t;

endpackage

`default_nettype wire

// ----- sv/cfb_front.sv -----
// ----------------------------------------------------------------------------
// cfb_front
// Accepts input words, tracks the open frame and checksum, emits operations.
// ----------------------------------------------------------------------------
`default_nettype none

module cfb_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire cfb_pkg::cfb_in_t    in_word,
  input  wire logic                q_full,
  output logic                     q_push,
  output cfb_pkg::cfb_entry_t      q_entry
);
  import cfb_pkg::*;

  logic       frame_open_r, frame_open_nxt;
  logic [7:0] bytes_left_r, bytes_left_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       accept;
  logic [7:0] len_byte;
  logic [7:0] hdr_sum;
  logic [7:0] pay_sum;
  logic [7:0] left_dec;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign len_byte = in_word.payload_length + LenBias;
  assign hdr_sum  = len_byte + in_word.packet_type + in_word.transaction_id + in_word.op_code;
  assign pay_sum  = sum_r + in_word.data_byte;
  assign left_dec = bytes_left_r - 8'd1;

  always_comb begin
    frame_open_nxt = frame_open_r;
    bytes_left_nxt = bytes_left_r;
    sum_nxt        = sum_r;
    q_push         = 1'b0;
    q_entry        = '0;
    if (accept) begin
      if (in_word.command == CMD_START) begin
        q_push            = 1'b1;
        q_entry.is_header = 1'b1;
        q_entry.b0        = len_byte;
        q_entry.b1        = in_word.packet_type;
        q_entry.b2        = in_word.transaction_id;
        q_entry.b3        = in_word.op_code;
        q_entry.ck        = 8'd0 - hdr_sum;
        if (in_word.payload_length == 8'd0) begin
          q_entry.has_ck = 1'b1;
          frame_open_nxt = 1'b0;
          bytes_left_nxt = 8'd0;
          sum_nxt        = 8'd0;
        end else begin
          frame_open_nxt = 1'b1;
          bytes_left_nxt = in_word.payload_length;
          sum_nxt        = hdr_sum;
        end
      end else if (frame_open_r) begin
        q_push     = 1'b1;
        q_entry.b0 = in_word.data_byte;
        q_entry.ck = 8'd0 - pay_sum;
        if (left_dec == 8'd0) begin
          q_entry.has_ck = 1'b1;
          frame_open_nxt = 1'b0;
          bytes_left_nxt = 8'd0;
          sum_nxt        = 8'd0;
        end else begin
          bytes_left_nxt = left_dec;
          sum_nxt        = pay_sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      bytes_left_r <= 8'd0;
      sum_r        <= 8'd0;
    end else begin
      frame_open_r <= frame_open_nxt;
      bytes_left_r <= bytes_left_nxt;
      sum_r        <= sum_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/cfb_queue.sv -----
// ----------------------------------------------------------------------------
// cfb_queue
// Short first-word-fall-through queue of operations between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module cfb_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire cfb_pkg::cfb_entry_t push_entry,
  output logic                     full,
  output logic                     head_valid,
  output cfb_pkg::cfb_entry_t      head_entry,
  input  wire logic                pop
);
  import cfb_pkg::*;

  cfb_entry_t             mem_r [QDepth];
  logic [QPtrWidth-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPtrWidth-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCntWidth-1:0]   count_r, count_nxt;

  assign full       = (count_r == QCntWidth'(QDepth));
  assign head_valid = (count_r != '0);
  assign head_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
      count_r <= QCntWidth'(QDepth))
    else $error("queue count out of range");

endmodule

`default_nettype wire

// ----- sv/cfb_back.sv -----
// ----------------------------------------------------------------------------
// cfb_back
// Expands queued operations into frame bytes through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cfb_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                head_valid,
  input  wire cfb_pkg::cfb_entry_t head_entry,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output cfb_pkg::cfb_out_t        out_word
);
  import cfb_pkg::*;

  localparam logic [2:0] StepSync0 = 3'd0;
  localparam logic [2:0] StepSync1 = 3'd1;
  localparam logic [2:0] StepLen   = 3'd2;
  localparam logic [2:0] StepType  = 3'd3;
  localparam logic [2:0] StepId    = 3'd4;
  localparam logic [2:0] StepOp    = 3'd5;
  localparam logic [2:0] StepCk    = 3'd6;

  logic [2:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  cfb_out_t   out_word_r, out_word_nxt;
  logic       advance;
  logic [2:0] last_step;
  logic       at_last;
  logic [7:0] sel_byte;

  assign advance   = head_valid && (!out_valid_r || !out_stall);
  assign last_step = head_entry.is_header ? (head_entry.has_ck ? StepCk : StepOp)
                                          : (head_entry.has_ck ? StepSync1 : StepSync0);
  assign at_last   = (step_r == last_step);
  assign pop       = advance && at_last;

  always_comb begin
    if (head_entry.is_header) begin
      unique case (step_r)
        StepSync0: sel_byte = SyncFirst;
        StepSync1: sel_byte = SyncSecond;
        StepLen:   sel_byte = head_entry.b0;
        StepType:  sel_byte = head_entry.b1;
        StepId:    sel_byte = head_entry.b2;
        StepOp:    sel_byte = head_entry.b3;
        default:   sel_byte = head_entry.ck;
      endcase
    end else begin
      sel_byte = (step_r == StepSync0) ? head_entry.b0 : head_entry.ck;
    end
  end

  always_comb begin
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (!out_valid_r || !out_stall) begin
      out_valid_nxt = head_valid;
    end
    if (advance) begin
      out_word_nxt.out_byte  = sel_byte;
      out_word_nxt.frame_end = head_entry.has_ck && at_last;
      step_nxt               = at_last ? StepSync0 : step_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= StepSync0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

// ----- sv/command_frame_builder_core.sv -----
// ----------------------------------------------------------------------------
// command_frame_builder_core
// Serial command frame encoder: sync, header, payload, two's complement sum.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | word
//  in_     | input     | in_valid/in_stall  | cfb_in_t  (start or payload)
//  out_    | output    | out_valid/out_stall| cfb_out_t (byte, frame_end)
//
//  Input words are taken one per cycle while the operation queue has room.
//  Output is one byte per cycle while out_stall is low and an operation is
//  queued: a start word gives 6 bytes (7 with an empty payload), a payload
//  word 1 byte (2 on the last one), all through the single output register.
//  Reset clears frame tracking, queue pointers and the output valid.
//  Input and output stall independently across a 4-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module command_frame_builder_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire cfb_pkg::cfb_in_t  in_word,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output cfb_pkg::cfb_out_t      out_word
);
  import cfb_pkg::*;

  logic       q_full;
  logic       q_push;
  cfb_entry_t q_entry;
  logic       q_head_valid;
  cfb_entry_t q_head;
  logic       q_pop;

  cfb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  cfb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head_entry (q_head),
    .pop        (q_pop)
  );

  cfb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_entry (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for command_frame_builder_core. Words go in on the
// in_ channel under random gaps and come back out against random stalls.
// Each accepted word runs through a local frame predictor that builds the
// expected byte stream. The stream covers sync, header, payload and the
// two's complement checksum. Every output byte is compared against the
// oldest expected byte.
// ----------------------------------------------------------------------------
module tb;
  import cfb_pkg::*;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  cfb_in_t  in_word = '0;
  logic     out_stall = 1'b0;
  logic     in_stall;
  logic     out_valid;
  cfb_out_t out_word;

  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int          mismatches = 0;

  cfb_out_t    frame_bytes_q[$];
  logic        frame_open_p = 1'b0;
  logic [7:0]  bytes_left_p = 8'd0;
  logic [7:0]  frame_sum_p = 8'd0;

  command_frame_builder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("[command_frame_builder_core] ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic void push_frame_byte(input logic [7:0] b, input logic last);
    cfb_out_t e;
    e.out_byte  = b;
    e.frame_end = last;
    frame_bytes_q.push_back(e);
  endfunction

  function automatic void close_frame();
    push_frame_byte(8'h00 - frame_sum_p, 1'b1);
    frame_open_p = 1'b0;
    bytes_left_p = 8'd0;
    frame_sum_p  = 8'd0;
  endfunction

  function automatic void predict_frame_bytes(input cfb_in_t w);
    logic [7:0] hdr [4];
    if (w.command == CMD_START) begin
      hdr[0] = w.payload_length + LenBias;
      hdr[1] = w.packet_type;
      hdr[2] = w.transaction_id;
      hdr[3] = w.op_code;
      frame_sum_p = 8'd0;
      push_frame_byte(SyncFirst, 1'b0);
      push_frame_byte(SyncSecond, 1'b0);
      foreach (hdr[i]) begin
        frame_sum_p = frame_sum_p + hdr[i];
        push_frame_byte(hdr[i], 1'b0);
      end
      if (w.payload_length == 8'd0) begin
        close_frame();
      end else begin
        frame_open_p = 1'b1;
        bytes_left_p = w.payload_length;
      end
    end else if (frame_open_p) begin
      frame_sum_p = frame_sum_p + w.data_byte;
      push_frame_byte(w.data_byte, 1'b0);
      bytes_left_p = bytes_left_p - 8'd1;
      if (bytes_left_p == 8'd0) close_frame();
    end
  endfunction

  function automatic cfb_in_t make_start(input logic [7:0] ptype, input logic [7:0] tid,
                                         input logic [7:0] op, input logic [7:0] len);
    cfb_in_t w;
    w.command        = CMD_START;
    w.packet_type    = ptype;
    w.transaction_id = tid;
    w.op_code        = op;
    w.payload_length = len;
    w.data_byte      = 8'($urandom);
    return w;
  endfunction

  function automatic cfb_in_t make_payload(input logic [7:0] b);
    cfb_in_t w;
    w.command        = CMD_PAYLOAD;
    w.packet_type    = 8'($urandom);
    w.transaction_id = 8'($urandom);
    w.op_code        = 8'($urandom);
    w.payload_length = 8'($urandom);
    w.data_byte      = b;
    return w;
  endfunction

  // Call at a rising edge; returns at the edge that accepts the word.
  task automatic send_word(input cfb_in_t w);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_frame_bytes(w);
  endtask

  task automatic send_random_start(input logic [7:0] len);
    send_word(make_start(8'($urandom), 8'($urandom), 8'($urandom), len));
  endtask

  task automatic send_random_payloads(input int count);
    repeat (count) send_word(make_payload(8'($urandom)));
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  always @(posedge clk) begin
    cfb_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_bytes_q.size() == 0) begin
        report_mismatch($sformatf("byte %02h with nothing expected", out_word.out_byte));
      end else begin
        want = frame_bytes_q.pop_front();
        if (out_word.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte %02h, expected %02h",
                                    out_word.out_byte, want.out_byte));
        if (out_word.frame_end !== want.frame_end)
          report_mismatch($sformatf("frame_end %b, expected %b on byte %02h",
                                    out_word.frame_end, want.frame_end, want.out_byte));
      end
    end
  end

  task automatic set_idle(input int unsigned src_pct, input int unsigned sink_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  task automatic test_header_extremes();
    send_word(make_start(8'h00, 8'h00, 8'h00, 8'd0));
    send_word(make_start(8'hFF, 8'hFF, 8'hFF, 8'd0));
    send_word(make_start(8'hA5, 8'h5A, 8'h3C, 8'd1));
    send_word(make_payload(8'hFF));
    send_word(make_start(8'h12, 8'h34, 8'h56, 8'd2));
    send_word(make_payload(8'h00));
    send_word(make_payload(8'h55));
    send_word(make_start(8'hFF, 8'h00, 8'hFF, 8'd3));
    send_word(make_payload(8'h80));
    send_word(make_payload(8'h01));
    send_word(make_payload(8'hFE));
  endtask

  task automatic test_stray_payload();
    send_word(make_payload(8'hC3));
    send_word(make_payload(8'h00));
    send_word(make_start(8'h01, 8'h02, 8'h03, 8'd0));
    send_word(make_payload(8'hFF));
  endtask

  task automatic test_abandoned_frame();
    send_word(make_start(8'h11, 8'h22, 8'h33, 8'd3));
    send_word(make_payload(8'h44));
    send_word(make_start(8'h66, 8'h77, 8'h88, 8'd1));
    send_word(make_payload(8'h99));
    send_word(make_start(8'hAA, 8'hBB, 8'hCC, 8'd4));
    send_word(make_start(8'hDD, 8'hEE, 8'hF0, 8'd0));
  endtask

  // Long frame whose length byte wraps past zero.
  task automatic test_long_frames();
    send_random_start(8'd251);
    send_random_payloads(251);
  endtask

  task automatic test_random_frames(input int target);
    int         sent;
    int unsigned pick;
    logic [7:0] len;
    int         cut;
    sent = 0;
    while (sent < target) begin
      pick = $urandom_range(99);
      len  = (pick < 6) ? 8'($urandom_range(9, 40)) : 8'($urandom_range(0, 8));
      send_random_start(len);
      sent++;
      if (len != 8'd0 && $urandom_range(99) < 10) begin
        cut = $urandom_range(0, int'(len) - 1);
        send_random_payloads(cut);
        sent += cut;
      end else begin
        send_random_payloads(int'(len));
        sent += int'(len);
        if ($urandom_range(99) < 10) send_random_payloads($urandom_range(1, 2));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    set_idle(30, 65);
    test_header_extremes();
    test_stray_payload();
    test_abandoned_frame();
    test_random_frames(40);

    set_idle(65, 30);
    test_long_frames();
    test_random_frames(40);

    set_idle(0, 0);
    test_random_frames(45);

    in_valid <= 1'b0;
    while (frame_bytes_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("[command_frame_builder_core] OK");
    end else begin
      $display("[command_frame_builder_core] ERROR");
    end
    $finish;
  end

endmodule
